@@ hdl/assert_macros.svh @@
// Assertion helpers for the allocator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

@@ hdl/nfa_pkg.sv @@
package nfa_pkg;
   localparam int MemBytes  = 1024;
   localparam int WordBits  = 32;
   localparam int Words     = MemBytes / WordBits;
   localparam int AddrW     = $clog2(MemBytes);
   localparam int WaddrW    = $clog2(Words);
   localparam int BitW      = $clog2(WordBits);
   localparam int CntW      = AddrW + 1;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_AREAD, ST_ASCAN, ST_MARK_RD, ST_MARK_WR,
      ST_FREE_RD, ST_FREE_WR, ST_QSCAN, ST_QEND, ST_RESP
   } state_type;
endpackage

@@ hdl/nfa_ram.sv @@
module nfa_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ hdl/next_fit_byte_allocator_core.sv @@
// Channel | Ports                                   | Direction
// req     | req_valid/ready, cmd,length,address,thr | in
// rsp     | rsp_valid/ready, status,granted,totals  | out
// After reset a clearing pass (one map word a cycle) covers all 32 words; no beat is taken.
// Allocate scans bit by bit from the rover, up to 1024 bits, then marks the run
// with a read and a write per map word. Query walks all 1024 bits.
// Free reads and writes each map word touched. Rate is set by the single bit
// scanner over the 32-bit map RAM. A waiting rsp beat stalls the next req.
`include "assert_macros.svh"
module next_fit_byte_allocator_core
   import nfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [11:0] req_length,
   input  logic [9:0]  req_address,
   input  logic [11:0] req_threshold,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [9:0]  rsp_granted_address,
   output logic [10:0] rsp_free_total,
   output logic [10:0] rsp_unusable_total
);
   state_type state_ff, state_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [11:0] len_ff, len_in, thr_ff, thr_in;
   logic [AddrW-1:0] rover_ff, rover_in, pos_ff, pos_in, start_ff, start_in;
   logic [AddrW-1:0] last_ff, last_in;
   logic [CntW-1:0] run_ff, run_in, step_ff, step_in, tot_ff, tot_in, unu_ff, unu_in;
   logic [11:0] left_ff, left_in;
   logic [WaddrW-1:0] clr_ff, clr_in;
   logic rv_ff, rv_in, st_ff, st_in;
   logic [AddrW-1:0] ga_ff, ga_in;
   logic [CntW-1:0] ft_ff, ft_in, ut_ff, ut_in;
   logic [WordBits-1:0] word_ff, word_in;
   logic word_ok_ff, word_ok_in;

   logic wr_en;
   logic [WaddrW-1:0] wr_addr, rd_addr;
   logic [WordBits-1:0] wr_data, rd_data, mask;
   logic [AddrW-1:0] span_end;
   logic [12:0] rem_word;
   logic bit_used;
   logic [CntW-1:0] run_n;

   nfa_ram #(.Width(WordBits), .Depth(Words)) u_map (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; rover_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; rover_ff <= rover_in; rv_ff <= rv_in;
      end
      cmd_ff <= cmd_in; len_ff <= len_in; thr_ff <= thr_in; pos_ff <= pos_in;
      start_ff <= start_in; last_ff <= last_in; run_ff <= run_in; step_ff <= step_in;
      tot_ff <= tot_in; unu_ff <= unu_in; left_ff <= left_in; st_ff <= st_in;
      ga_ff <= ga_in; ft_ff <= ft_in; ut_ff <= ut_in; word_ff <= word_in;
      word_ok_ff <= word_ok_in;
   end

   // current bit comes from the fresh read or the held word
   assign bit_used = word_ok_ff ? word_ff[pos_ff[BitW-1:0]] : rd_data[pos_ff[BitW-1:0]];

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; len_in = len_ff; thr_in = thr_ff;
      rover_in = rover_ff; pos_in = pos_ff; start_in = start_ff; last_in = last_ff;
      run_in = run_ff; step_in = step_ff; tot_in = tot_ff; unu_in = unu_ff;
      left_in = left_ff; clr_in = clr_ff; rv_in = rv_ff; st_in = st_ff; ga_in = ga_ff;
      ft_in = ft_ff; ut_in = ut_ff; word_in = word_ff; word_ok_in = word_ok_ff;
      wr_en = 1'b0; wr_addr = pos_ff[AddrW-1:BitW]; wr_data = '0;
      rd_addr = pos_ff[AddrW-1:BitW]; req_ready = 1'b0; mask = '0;
      run_n = '0; span_end = '0; rem_word = '0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1; wr_addr = clr_ff; wr_data = '0; clr_in = clr_ff + 1'b1;
            if (clr_ff == WaddrW'(Words - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = !rv_ff;
            if (req_valid && !rv_ff) begin
               cmd_in = req_cmd; len_in = req_length; thr_in = req_threshold;
               st_in = 1'b0; ga_in = '0; ft_in = '0; ut_in = '0;
               word_ok_in = 1'b0; run_in = '0; step_in = '0; tot_in = '0; unu_in = '0;
               unique case (req_cmd)
                  CMD_ALLOC: begin
                     pos_in = rover_ff;
                     if (req_length == '0 || req_length > 12'(MemBytes)) begin
                        st_in = 1'b1; state_in = ST_RESP;
                     end else state_in = ST_AREAD;
                  end
                  CMD_FREE: begin
                     pos_in = req_address; left_in = req_length;
                     state_in = (req_length == '0) ? ST_RESP : ST_FREE_RD;
                  end
                  CMD_QUERY: begin pos_in = '0; state_in = ST_AREAD; end
                  default: begin st_in = 1'b1; state_in = ST_RESP; end
               endcase
            end
         end
         ST_AREAD: state_in = (cmd_ff == CMD_QUERY) ? ST_QSCAN : ST_ASCAN;
         ST_ASCAN: begin
            // examine one bit; hold the word until crossing a boundary
            word_in = word_ok_ff ? word_ff : rd_data; word_ok_in = 1'b1;
            run_n = (pos_ff == '0) ? CntW'(0) : run_ff;
            run_n = bit_used ? CntW'(0) : run_n + 1'b1;
            run_in = run_n; step_in = step_ff + 1'b1; pos_in = pos_ff + 1'b1;
            if (pos_ff[BitW-1:0] == '1) begin
               word_ok_in = 1'b0; rd_addr = pos_in[AddrW-1:BitW];
            end
            if (12'(run_n) == len_ff) begin
               start_in = pos_ff + 1'b1 - AddrW'(len_ff); last_in = pos_ff;
               ga_in = start_in; rover_in = pos_ff + 1'b1;
               pos_in = start_in; state_in = ST_MARK_RD;
            end else if (step_ff == CntW'(MemBytes - 1)) begin
               st_in = 1'b1; state_in = ST_RESP;
            end
         end
         ST_MARK_RD: state_in = ST_MARK_WR;
         ST_MARK_WR: begin
            // set bits pos..min(word end, last)
            span_end = (pos_ff[AddrW-1:BitW] == last_ff[AddrW-1:BitW]) ?
                       last_ff : {pos_ff[AddrW-1:BitW], {BitW{1'b1}}};
            for (int b = 0; b < WordBits; b++)
               mask[b] = (BitW'(b) >= pos_ff[BitW-1:0]) && (BitW'(b) <= span_end[BitW-1:0]);
            wr_en = 1'b1; wr_data = rd_data | mask;
            if (span_end == last_ff) state_in = ST_RESP;
            else begin
               pos_in = span_end + 1'b1; rd_addr = pos_in[AddrW-1:BitW];
               state_in = ST_MARK_RD;
            end
         end
         ST_FREE_RD: state_in = ST_FREE_WR;
         ST_FREE_WR: begin
            rem_word = 13'(WordBits) - 13'(pos_ff[BitW-1:0]);
            if ({1'b0, left_ff} <= rem_word)
               span_end = pos_ff + AddrW'(left_ff - 1'b1);
            else span_end = {pos_ff[AddrW-1:BitW], {BitW{1'b1}}};
            for (int b = 0; b < WordBits; b++)
               mask[b] = (BitW'(b) >= pos_ff[BitW-1:0]) && (BitW'(b) <= span_end[BitW-1:0]);
            wr_en = 1'b1; wr_data = rd_data & ~mask;
            left_in = left_ff - 12'(span_end[BitW-1:0] - pos_ff[BitW-1:0]) - 1'b1;
            if ({1'b0, left_ff} <= rem_word || span_end == '1) state_in = ST_RESP;
            else begin
               pos_in = span_end + 1'b1; rd_addr = pos_in[AddrW-1:BitW];
               state_in = ST_FREE_RD;
            end
         end
         ST_QSCAN: begin
            word_in = word_ok_ff ? word_ff : rd_data; word_ok_in = 1'b1;
            pos_in = pos_ff + 1'b1;
            if (pos_ff[BitW-1:0] == '1) begin
               word_ok_in = 1'b0; rd_addr = pos_in[AddrW-1:BitW];
            end
            if (!bit_used) begin
               tot_in = tot_ff + 1'b1; run_in = run_ff + 1'b1;
            end else begin
               if (run_ff != '0 && 12'(run_ff) < thr_ff) unu_in = unu_ff + run_ff;
               run_in = '0;
            end
            if (pos_ff == '1) state_in = ST_QEND;
         end
         ST_QEND: begin
            ft_in = tot_ff;
            ut_in = (run_ff != '0 && 12'(run_ff) < thr_ff) ? unu_ff + run_ff : unu_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin rv_in = 1'b1; state_in = ST_IDLE; end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_granted_address = ga_ff;
   assign rsp_free_total = ft_ff;
   assign rsp_unusable_total = ut_ff;

   `ASSERT_CLK(a_no_take_busy, clock, reset, req_ready |-> state_ff == ST_IDLE, "ready outside idle")
   `ASSERT_CLK(a_fail_zero, clock, reset, (rsp_valid && rsp_status) |-> rsp_granted_address == '0, "fail with address")
   `ASSERT_CLK(a_free_le, clock, reset, rsp_valid |-> rsp_unusable_total <= rsp_free_total, "unusable above free")
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import nfa_pkg::*;

   localparam logic [1:0] CMD_BAD = 2'd3;
   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int RANDOM_ITEMS = 1950;
   localparam int CALM_ITEMS = 200;

   typedef struct packed {
      logic        status;
      logic [9:0]  granted;
      logic [10:0] free_total;
      logic [10:0] unusable_total;
   } alloc_answer_type;

   typedef struct {
      int unsigned base;
      int unsigned size;
   } region_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic [11:0] req_length;
   logic [9:0]  req_address;
   logic [11:0] req_threshold;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_status;
   logic [9:0]  rsp_granted_address;
   logic [10:0] rsp_free_total;
   logic [10:0] rsp_unusable_total;

   // predictor state: byte occupancy and next-fit pointer
   bit [MemBytes-1:0] byte_used;
   int unsigned       next_fit_ptr;

   alloc_answer_type pending_answers[$];
   region_type       live_regions[$];
   int               mismatch_count;
   int               cycle_count;
   bit               idle_on;

   next_fit_byte_allocator_core uut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic alloc_answer_type predict_alloc(input int unsigned len);
      alloc_answer_type ans;
      int unsigned      run;
      int unsigned      pos;
      int unsigned      start;
      ans = '0;
      ans.status = 1'b1;
      run = 0;
      if (len == 0 || len > MemBytes) return ans;
      for (int unsigned k = 0; k < MemBytes; k++) begin
         pos = (next_fit_ptr + k) % MemBytes;
         // a run never crosses from the last byte back to byte zero
         if (pos == 0) run = 0;
         if (!byte_used[pos]) run++;
         else run = 0;
         if (run == len) begin
            start = pos + 1 - len;
            for (int unsigned i = 0; i < len; i++) byte_used[start + i] = 1'b1;
            next_fit_ptr = (start + len) % MemBytes;
            ans.status = 1'b0;
            ans.granted = start[9:0];
            live_regions.push_back('{start, len});
            return ans;
         end
      end
      return ans;
   endfunction

   function automatic alloc_answer_type predict_beat(input logic [1:0] cmd,
         input logic [11:0] len, input logic [9:0] addr, input logic [11:0] thr);
      alloc_answer_type ans;
      int unsigned      run;
      int unsigned      total;
      int unsigned      unusable;
      ans = '0;
      run = 0;
      total = 0;
      unusable = 0;
      case (cmd)
         CMD_ALLOC: ans = predict_alloc(len);
         CMD_FREE: begin
            // clip at the end of memory
            for (int unsigned i = 0; i < len && addr + i < MemBytes; i++)
               byte_used[addr + i] = 1'b0;
         end
         CMD_QUERY: begin
            for (int unsigned i = 0; i <= MemBytes; i++) begin
               if (i < MemBytes && !byte_used[i]) begin
                  total++;
                  run++;
               end else begin
                  if (run > 0 && run < thr) unusable += run;
                  run = 0;
               end
            end
            ans.free_total = total[10:0];
            ans.unusable_total = unusable[10:0];
         end
         default: ans.status = 1'b1;
      endcase
      return ans;
   endfunction

   // drive one request beat; valid stays high across back-to-back beats
   task automatic send_beat(input logic [1:0] cmd, input int unsigned len,
         input int unsigned addr, input int unsigned thr);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_length    <= len[11:0];
      req_address   <= addr[9:0];
      req_threshold <= thr[11:0];
      do @(posedge clock); while (!req_ready);
      pending_answers.push_back(predict_beat(cmd, len[11:0], addr[9:0], thr[11:0]));
   endtask

   // response side stalls in bursts
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 15);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each response beat with the oldest prediction
   always @(posedge clock) begin
      alloc_answer_type exp_ans;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response beat");
         end else begin
            exp_ans = pending_answers.pop_front();
            if (rsp_status !== exp_ans.status || rsp_granted_address !== exp_ans.granted
                  || rsp_free_total !== exp_ans.free_total
                  || rsp_unusable_total !== exp_ans.unusable_total) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: exp st=%0d ga=%0d ft=%0d ut=%0d",
                     " got st=%0d ga=%0d ft=%0d ut=%0d"},
                     exp_ans.status, exp_ans.granted, exp_ans.free_total,
                     exp_ans.unusable_total, rsp_status, rsp_granted_address,
                     rsp_free_total, rsp_unusable_total);
            end
         end
      end
   end

   // boundary lengths, full map, clipping, wrap and bad command
   task automatic test_directed;
      send_beat(CMD_QUERY, 0, 0, 0);
      send_beat(CMD_ALLOC, 0, 0, 0);
      send_beat(CMD_ALLOC, 1025, 0, 0);
      send_beat(CMD_ALLOC, 4095, 0, 0);
      send_beat(CMD_ALLOC, 1024, 0, 0);
      send_beat(CMD_ALLOC, 1, 0, 0);
      send_beat(CMD_QUERY, 0, 0, 4095);
      send_beat(CMD_FREE, 4095, 1023, 0);
      send_beat(CMD_FREE, 0, 5, 0);
      send_beat(CMD_QUERY, 0, 0, 1);
      send_beat(CMD_FREE, 4095, 0, 0);
      send_beat(CMD_ALLOC, 10, 0, 0);
      send_beat(CMD_ALLOC, 1014, 0, 0);
      send_beat(CMD_FREE, 4, 1020, 0);
      send_beat(CMD_FREE, 4, 0, 0);
      // free bytes sit on both sides of the wrap: no joined run
      send_beat(CMD_ALLOC, 8, 0, 0);
      send_beat(CMD_QUERY, 0, 0, 5);
      send_beat(CMD_ALLOC, 4, 0, 0);
      send_beat(CMD_ALLOC, 4, 0, 0);
      send_beat(CMD_BAD, 4095, 1023, 4095);
      send_beat(CMD_QUERY, 0, 0, 2);
      send_beat(CMD_FREE, 4095, 0, 0);
      live_regions.delete();
   endtask

   // mostly allocate/free traffic with occasional queries and junk
   task automatic test_random_traffic(input int count);
      int unsigned pick;
      int unsigned len;
      int unsigned idx;
      region_type  reg_item;
      for (int n = 0; n < count; n++) begin
         if (n == count - CALM_ITEMS) idle_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            case ($urandom_range(0, 9))
               0: len = $urandom_range(0, 4095);
               1: len = $urandom_range(65, 1024);
               default: len = $urandom_range(1, 64);
            endcase
            send_beat(CMD_ALLOC, len, $urandom_range(0, 1023), $urandom_range(0, 4095));
         end else if (pick < 80) begin
            if (live_regions.size() > 0 && $urandom_range(0, 4) != 0) begin
               idx = $urandom_range(0, live_regions.size() - 1);
               reg_item = live_regions[idx];
               live_regions.delete(idx);
               send_beat(CMD_FREE, reg_item.size, reg_item.base, $urandom_range(0, 4095));
            end else begin
               send_beat(CMD_FREE, $urandom_range(0, 4095), $urandom_range(0, 1023),
                  $urandom_range(0, 4095));
            end
         end else if (pick < 95) begin
            send_beat(CMD_QUERY, $urandom_range(0, 4095), $urandom_range(0, 1023),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 64));
         end else begin
            send_beat(CMD_BAD, $urandom_range(0, 4095), $urandom_range(0, 1023),
               $urandom_range(0, 4095));
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_cmd       = CMD_ALLOC;
      req_length    = '0;
      req_address   = '0;
      req_threshold = '0;
      byte_used     = '0;
      next_fit_ptr  = 0;
      mismatch_count = 0;
      cycle_count   = 0;
      idle_on       = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_traffic(RANDOM_ITEMS);

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_answers.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
